### design/imd2_pkg.sv
// shared types, constants and functions of the iterated md2 hash engine
// no dependencies; imported by imd2_absorb and iterated_md2_hash_engine
package imd2_pkg;

  typedef logic [7:0] octet_t;
  typedef logic [15:0][7:0] blk16_t;
  typedef logic [7:0] sbox_t [256];

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
    logic       empty_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic [3:0] byte_index;
    logic       final_byte;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic clear;
  } abs_ctrl_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_CSUM,
    A_LOAD,
    A_MIX
  } abs_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_KICK,
    S_ABS,
    S_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    STEP_BLOCK,
    STEP_PAD,
    STEP_CSUM,
    STEP_HEX_HI,
    STEP_HEX_LO
  } step_e;

  localparam logic CFG_ITER = 1'b0;
  localparam logic CFG_HEX  = 1'b1;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned MIX_BYTES   = 48;
  localparam int unsigned ROUNDS      = 18;
  localparam octet_t      FULL_PAD    = 8'h10;

  localparam sbox_t SBOX = '{
    8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01,
    8'h3D, 8'h36, 8'h54, 8'hA1, 8'hEC, 8'hF0, 8'h06, 8'h13,
    8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
    8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA,
    8'h1E, 8'h9B, 8'h57, 8'h3C, 8'hFD, 8'hD4, 8'hE0, 8'h16,
    8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
    8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49,
    8'hA0, 8'hFB, 8'hF5, 8'h8E, 8'hBB, 8'h2F, 8'hEE, 8'h7A,
    8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
    8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21,
    8'h80, 8'h7F, 8'h5D, 8'h9A, 8'h5A, 8'h90, 8'h32, 8'h27,
    8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
    8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1,
    8'hD7, 8'h5E, 8'h92, 8'h2A, 8'hAC, 8'h56, 8'hAA, 8'hC6,
    8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
    8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1,
    8'h45, 8'h9D, 8'h70, 8'h59, 8'h64, 8'h71, 8'h87, 8'h20,
    8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
    8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6,
    8'h1C, 8'h46, 8'h61, 8'h69, 8'h34, 8'h40, 8'h7E, 8'h0F,
    8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
    8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26,
    8'h2C, 8'h53, 8'h0D, 8'h6E, 8'h85, 8'h28, 8'h84, 8'h09,
    8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
    8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA,
    8'h24, 8'hE1, 8'h7B, 8'h08, 8'h0C, 8'hBD, 8'hB1, 8'h4A,
    8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
    8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39,
    8'hF2, 8'hEF, 8'hB7, 8'h0E, 8'h66, 8'h58, 8'hD0, 8'hE4,
    8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
    8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A,
    8'hDB, 8'h99, 8'h8D, 8'h33, 8'h9F, 8'h11, 8'h83, 8'h14
  };

  // ascii hex digit of one nibble
  function automatic octet_t hex_char(input logic [3:0] nib, input logic upper);
    octet_t r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else if (upper) begin
      r = 8'h41 + {4'd0, nib - 4'd10};
    end else begin
      r = 8'h61 + {4'd0, nib - 4'd10};
    end
    return r;
  endfunction

endpackage

### design/iterated_md2_hash_engine.sv
// iterated md2 hash engine: byte gathering, padding, re-hash of hex text, digest output
// one transaction per cycle while gathering; a full 16-byte block holds the input until it is absorbed
// (start, checksum, load, mix and done steps through the s-box path of imd2_absorb)
// message end: a pad step and two absorbs (pad block, checksum), plus four absorbs per extra iteration,
// then 16 output transactions; async active-low reset returns to idle with zero hash state
// depends on imd2_pkg and imd2_absorb
module iterated_md2_hash_engine import imd2_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  top_state_e  state_q, state_d;
  step_e       step_q;
  blk16_t      blk_q, pd_q;
  logic [3:0]  fill_q, oidx_q;
  logic        last_pend_q;
  logic [31:0] passes_q, iter_q;
  logic        hex_q;
  abs_ctrl_t   actrl;
  logic        abs_done;
  blk16_t      x_lo, c_cur;
  logic        in_acc, out_acc, more, abs_fin;
  logic [31:0] total;
  logic [32:0] passes_inc;

  imd2_absorb u_abs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (actrl),
    .blk_i  (blk_q),
    .done_o (abs_done),
    .x_lo_o (x_lo),
    .c_o    (c_cur)
  );

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign total      = (iter_q == '0) ? 32'd1 : iter_q;
  assign passes_inc = {1'b0, passes_q} + 33'd1;
  assign more       = passes_inc < {1'b0, total};
  assign abs_fin    = (state_q == S_ABS) && abs_done;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_data_i.empty_end && fill_q == 4'd15) state_d = S_KICK;
          else if (in_data_i.last_byte) state_d = S_PAD;
        end
      end
      S_PAD:  state_d = S_KICK;
      S_KICK: state_d = S_ABS;
      S_ABS: begin
        if (abs_done) begin
          unique case (step_q)
            STEP_BLOCK: state_d = last_pend_q ? S_PAD : S_IDLE;
            STEP_CSUM:  state_d = more ? S_KICK : S_OUT;
            default:    state_d = S_KICK;
          endcase
        end
      end
      S_OUT: if (out_acc && oidx_q == 4'd15) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o             = (state_q == S_IDLE);
    cfg_ready_o            = 1'b1;
    out_valid_o            = (state_q == S_OUT);
    out_data_o.digest_byte = pd_q[oidx_q];
    out_data_o.byte_index  = oidx_q;
    out_data_o.final_byte  = (oidx_q == 4'd15);
    actrl.start            = (state_q == S_KICK);
    actrl.clear            = (abs_fin && step_q == STEP_CSUM && more) ||
                             (out_acc && oidx_q == 4'd15);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_BLOCK;
      fill_q      <= '0;
      oidx_q      <= '0;
      last_pend_q <= 1'b0;
      passes_q    <= '0;
      iter_q      <= 32'd1;
      hex_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ITER: iter_q <= cfg_data_i;
          CFG_HEX:  hex_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && !in_data_i.empty_end) begin
            if (fill_q == 4'd15) begin
              fill_q      <= '0;
              step_q      <= STEP_BLOCK;
              last_pend_q <= in_data_i.last_byte;
            end else begin
              fill_q <= fill_q + 4'd1;
            end
          end
        end
        S_PAD: begin
          step_q <= STEP_PAD;
          fill_q <= '0;
        end
        S_ABS: begin
          if (abs_done) begin
            unique case (step_q)
              STEP_BLOCK: last_pend_q <= 1'b0;
              STEP_PAD:   step_q <= STEP_CSUM;
              STEP_CSUM: begin
                passes_q <= passes_inc[31:0];
                oidx_q   <= '0;
                if (more) step_q <= STEP_HEX_HI;
              end
              STEP_HEX_HI: step_q <= STEP_HEX_LO;
              STEP_HEX_LO: step_q <= STEP_PAD;
              default: ;
            endcase
          end
        end
        S_OUT: begin
          if (out_acc) begin
            oidx_q <= oidx_q + 4'd1;
            if (oidx_q == 4'd15) passes_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // block and digest holding registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && !in_data_i.empty_end) blk_q[fill_q] <= in_data_i.msg_byte;
      end
      S_PAD: begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
          if (4'(i) >= fill_q) blk_q[i] <= FULL_PAD - {4'd0, fill_q};
        end
      end
      S_ABS: begin
        if (abs_done) begin
          unique case (step_q)
            STEP_PAD: blk_q <= c_cur;
            STEP_CSUM: begin
              pd_q <= x_lo;
              for (int j = 0; j < BLOCK_BYTES / 2; j++) begin
                blk_q[2*j]   <= hex_char(x_lo[j][7:4], hex_q);
                blk_q[2*j+1] <= hex_char(x_lo[j][3:0], hex_q);
              end
            end
            STEP_HEX_HI: begin
              for (int j = 0; j < BLOCK_BYTES / 2; j++) begin
                blk_q[2*j]   <= hex_char(pd_q[BLOCK_BYTES/2+j][7:4], hex_q);
                blk_q[2*j+1] <= hex_char(pd_q[BLOCK_BYTES/2+j][3:0], hex_q);
              end
            end
            STEP_HEX_LO: begin
              for (int i = 0; i < BLOCK_BYTES; i++) blk_q[i] <= FULL_PAD;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  a_no_input_while_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open during digest output");

  a_idle_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.final_byte) |=> (in_ready_o && !out_valid_o))
    else $error("engine not idle after last digest byte");

  a_start_only_from_kick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    actrl.start |=> (state_q == S_ABS && !abs_done))
    else $error("absorb start not followed by busy wait");

endmodule

### design/imd2_absorb.sv
// md2 block absorb unit: checksum update and 18-round mix, one s-box step a cycle
// holds the 48-byte mix state and the 16-byte checksum; uses imd2_pkg
module imd2_absorb import imd2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  abs_ctrl_t ctrl_i,
  input  blk16_t    blk_i,
  output logic      done_o,
  output blk16_t    x_lo_o,
  output blk16_t    c_o
);

  abs_state_e state_q, state_d;
  octet_t     x_q [MIX_BYTES];
  octet_t     c_q [BLOCK_BYTES];
  octet_t     b_q [BLOCK_BYTES];
  octet_t     t_q;
  logic [5:0] cnt_q;
  logic [4:0] rnd_q;
  logic       done_q;
  logic       csum_last, pos_last, rnd_last;
  octet_t     new_c, new_x;

  assign csum_last = (cnt_q == 6'(BLOCK_BYTES - 1));
  assign pos_last  = (cnt_q == 6'(MIX_BYTES - 1));
  assign rnd_last  = (rnd_q == 5'(ROUNDS - 1));
  assign new_c     = c_q[0] ^ SBOX[b_q[0] ^ t_q];
  assign new_x     = x_q[0] ^ SBOX[t_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      A_IDLE: if (ctrl_i.start) state_d = A_CSUM;
      A_CSUM: if (csum_last) state_d = A_LOAD;
      A_LOAD: state_d = A_MIX;
      A_MIX:  if (pos_last && rnd_last) state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_comb begin
    done_o = done_q;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      x_lo_o[i] = x_q[i];
      c_o[i]    = c_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      for (int i = 0; i < MIX_BYTES; i++) x_q[i] <= '0;
      for (int i = 0; i < BLOCK_BYTES; i++) c_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        A_IDLE: begin
          if (ctrl_i.start) begin
            done_q <= 1'b0;
            cnt_q  <= '0;
          end else if (ctrl_i.clear) begin
            for (int i = 0; i < MIX_BYTES; i++) x_q[i] <= '0;
            for (int i = 0; i < BLOCK_BYTES; i++) c_q[i] <= '0;
          end
        end
        A_CSUM: begin
          // checksum and block rotate together, so c[0] and b[0] are always the current byte
          for (int i = 0; i < BLOCK_BYTES - 1; i++) c_q[i] <= c_q[i+1];
          c_q[BLOCK_BYTES-1] <= new_c;
          cnt_q <= cnt_q + 6'd1;
        end
        A_LOAD: begin
          for (int i = 0; i < BLOCK_BYTES; i++) begin
            x_q[BLOCK_BYTES+i]   <= b_q[i];
            x_q[2*BLOCK_BYTES+i] <= b_q[i] ^ x_q[i];
          end
          cnt_q <= '0;
          rnd_q <= '0;
        end
        A_MIX: begin
          for (int i = 0; i < MIX_BYTES - 1; i++) x_q[i] <= x_q[i+1];
          x_q[MIX_BYTES-1] <= new_x;
          if (pos_last) begin
            cnt_q <= '0;
            rnd_q <= rnd_q + 5'd1;
            if (rnd_last) done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) begin
          for (int i = 0; i < BLOCK_BYTES; i++) b_q[i] <= blk_i[i];
          t_q <= c_q[BLOCK_BYTES-1];
        end
      end
      A_CSUM: begin
        for (int i = 0; i < BLOCK_BYTES - 1; i++) b_q[i] <= b_q[i+1];
        b_q[BLOCK_BYTES-1] <= b_q[0];
        t_q <= new_c;
      end
      A_LOAD: t_q <= '0;
      A_MIX: t_q <= pos_last ? new_x + {3'd0, rnd_q} : new_x;
      default: ;
    endcase
  end

endmodule
